>>> rtl/cetto_pkg.sv
// ----------------------------------------------------------------------------
// cetto_pkg
// Shared types, codes, saturating arithmetic and the controller program
// for the cubic escape-time unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cetto_pkg;

   // Defaults for the top-level parameters.
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 24;

   // Internal working format: signed 64-bit, FRAC_BITS fraction bits.
   localparam int WORK_WIDTH = 64;
   localparam int HALF_WIDTH = WORK_WIDTH / 2;
   localparam int COUNT_WIDTH = 16;
   localparam int CODE_WIDTH = 19;

   localparam logic signed [WORK_WIDTH-1:0] WORK_MAX  = {1'b0, {(WORK_WIDTH-1){1'b1}}};
   localparam logic signed [WORK_WIDTH-1:0] WORK_MIN  = {1'b1, {(WORK_WIDTH-1){1'b0}}};
   localparam logic signed [WORK_WIDTH-1:0] WORK_ZERO = '0;

   localparam logic signed [CODE_WIDTH-1:0] CODE_BOUNDED     = '1;
   localparam logic signed [CODE_WIDTH-1:0] CODE_BAND_OFFSET = CODE_WIDTH'(21);

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   localparam csr_index_type CSR_SIGN_A   = 2'd0;
   localparam csr_index_type CSR_SIGN_B   = 2'd1;
   localparam csr_index_type CSR_MAX_ITER = 2'd2;

   localparam logic                   SIGN_A_RESET   = 1'b1;
   localparam logic                   SIGN_B_RESET   = 1'b0;
   localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(100);

   // Datapath operations.
   typedef logic [3:0] op_type;
   localparam op_type OP_NOP    = 4'd0;
   localparam op_type OP_LOAD   = 4'd1;
   localparam op_type OP_MUL    = 4'd2;
   localparam op_type OP_NEGA   = 4'd3;
   localparam op_type OP_ADD    = 4'd4;
   localparam op_type OP_SUB    = 4'd5;
   localparam op_type OP_INITP  = 4'd6;
   localparam op_type OP_INITN  = 4'd7;
   localparam op_type OP_STEP   = 4'd8;
   localparam op_type OP_SAVE   = 4'd9;
   localparam op_type OP_FINISH = 4'd10;

   // Datapath register selects.
   typedef logic [3:0] sel_type;
   localparam sel_type SEL_A   = 4'd0;
   localparam sel_type SEL_RE  = 4'd1;
   localparam sel_type SEL_IM  = 4'd2;
   localparam sel_type SEL_RE2 = 4'd3;
   localparam sel_type SEL_IM2 = 4'd4;
   localparam sel_type SEL_A3  = 4'd5;
   localparam sel_type SEL_BRE = 4'd6;
   localparam sel_type SEL_BIM = 4'd7;
   localparam sel_type SEL_T1  = 4'd8;
   localparam sel_type SEL_T2  = 4'd9;
   localparam sel_type SEL_P0  = 4'd10;
   localparam sel_type SEL_P1  = 4'd11;

   // Sequencer flow control.
   typedef logic [2:0] flow_type;
   localparam flow_type FL_NEXT      = 3'd0;
   localparam flow_type FL_JUMP      = 3'd1;
   localparam flow_type FL_IF_LIMIT  = 3'd2;
   localparam flow_type FL_IF_ESCAPE = 3'd3;
   localparam flow_type FL_ORBIT_END = 3'd4;
   localparam flow_type FL_END       = 3'd5;

   typedef logic [4:0] pc_type;
   localparam pc_type PC_ORBIT_TOP = 5'd6;
   localparam pc_type PC_ORBIT_END = 5'd24;
   localparam pc_type PC_FINISH    = 5'd26;

   typedef struct packed {
      op_type   op;
      sel_type  src_a;
      sel_type  src_b;
      sel_type  dst;
      flow_type flow;
      pc_type   target;
   } instr_type;

   typedef struct packed {
      logic    valid;
      op_type  op;
      sel_type src_a;
      sel_type src_b;
      sel_type dst;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic at_limit;
      logic escaped;
      logic pair_mode;
      logic orbit2;
   } status_type;

   function automatic logic signed [WORK_WIDTH-1:0] sat_add(
      input logic signed [WORK_WIDTH-1:0] x,
      input logic signed [WORK_WIDTH-1:0] y);
      logic signed [WORK_WIDTH:0] s;
      s = {x[WORK_WIDTH-1], x} + {y[WORK_WIDTH-1], y};
      if (s[WORK_WIDTH] != s[WORK_WIDTH-1]) begin
         return s[WORK_WIDTH] ? WORK_MIN : WORK_MAX;
      end
      return s[WORK_WIDTH-1:0];
   endfunction

   function automatic logic signed [WORK_WIDTH-1:0] sat_sub(
      input logic signed [WORK_WIDTH-1:0] x,
      input logic signed [WORK_WIDTH-1:0] y);
      logic signed [WORK_WIDTH:0] s;
      s = {x[WORK_WIDTH-1], x} - {y[WORK_WIDTH-1], y};
      if (s[WORK_WIDTH] != s[WORK_WIDTH-1]) begin
         return s[WORK_WIDTH] ? WORK_MIN : WORK_MAX;
      end
      return s[WORK_WIDTH-1:0];
   endfunction

   function automatic instr_type mk(input op_type op, input sel_type sa,
                                    input sel_type sb, input sel_type dst,
                                    input flow_type flow, input pc_type target);
      instr_type r;
      r.op     = op;
      r.src_a  = sa;
      r.src_b  = sb;
      r.dst    = dst;
      r.flow   = flow;
      r.target = target;
      return r;
   endfunction

   // Controller program. One orbit runs from PC_ORBIT_TOP to PC_ORBIT_END;
   // the second orbit re-enters it after the negated start point is loaded.
   function automatic instr_type prog_rom(input pc_type pc);
      instr_type r;
      case (pc)
         5'd0:  r = mk(OP_LOAD,   SEL_A,   SEL_A,   SEL_A,   FL_NEXT, '0);
         5'd1:  r = mk(OP_MUL,    SEL_A,   SEL_A,   SEL_A3,  FL_NEXT, '0);
         5'd2:  r = mk(OP_NEGA,   SEL_A,   SEL_A,   SEL_A3,  FL_NEXT, '0);
         5'd3:  r = mk(OP_ADD,    SEL_A3,  SEL_A3,  SEL_T1,  FL_NEXT, '0);
         5'd4:  r = mk(OP_ADD,    SEL_A3,  SEL_T1,  SEL_A3,  FL_NEXT, '0);
         5'd5:  r = mk(OP_INITP,  SEL_A,   SEL_A,   SEL_A,   FL_NEXT, '0);
         5'd6:  r = mk(OP_MUL,    SEL_RE,  SEL_RE,  SEL_RE2, FL_NEXT, '0);
         5'd7:  r = mk(OP_MUL,    SEL_IM,  SEL_IM,  SEL_IM2, FL_NEXT, '0);
         5'd8:  r = mk(OP_NOP,    SEL_A,   SEL_A,   SEL_A,   FL_IF_LIMIT, PC_ORBIT_END);
         5'd9:  r = mk(OP_ADD,    SEL_RE2, SEL_IM2, SEL_P0,  FL_NEXT, '0);
         5'd10: r = mk(OP_NOP,    SEL_A,   SEL_A,   SEL_A,   FL_IF_ESCAPE, PC_ORBIT_END);
         5'd11: r = mk(OP_SUB,    SEL_RE2, SEL_IM2, SEL_T1,  FL_NEXT, '0);
         5'd12: r = mk(OP_SUB,    SEL_T1,  SEL_A3,  SEL_T1,  FL_NEXT, '0);
         5'd13: r = mk(OP_MUL,    SEL_RE,  SEL_IM,  SEL_T2,  FL_NEXT, '0);
         5'd14: r = mk(OP_ADD,    SEL_T2,  SEL_T2,  SEL_T2,  FL_NEXT, '0);
         5'd15: r = mk(OP_MUL,    SEL_T1,  SEL_RE,  SEL_P0,  FL_NEXT, '0);
         5'd16: r = mk(OP_MUL,    SEL_T2,  SEL_IM,  SEL_P1,  FL_NEXT, '0);
         5'd17: r = mk(OP_SUB,    SEL_P0,  SEL_P1,  SEL_P0,  FL_NEXT, '0);
         5'd18: r = mk(OP_ADD,    SEL_P0,  SEL_BRE, SEL_P0,  FL_NEXT, '0);
         5'd19: r = mk(OP_MUL,    SEL_T1,  SEL_IM,  SEL_P1,  FL_NEXT, '0);
         5'd20: r = mk(OP_MUL,    SEL_T2,  SEL_RE,  SEL_T1,  FL_NEXT, '0);
         5'd21: r = mk(OP_ADD,    SEL_P1,  SEL_T1,  SEL_P1,  FL_NEXT, '0);
         5'd22: r = mk(OP_ADD,    SEL_P1,  SEL_BIM, SEL_P1,  FL_NEXT, '0);
         5'd23: r = mk(OP_STEP,   SEL_A,   SEL_A,   SEL_A,   FL_JUMP, PC_ORBIT_TOP);
         5'd24: r = mk(OP_SAVE,   SEL_A,   SEL_A,   SEL_A,   FL_ORBIT_END, PC_FINISH);
         5'd25: r = mk(OP_INITN,  SEL_A,   SEL_A,   SEL_A,   FL_JUMP, PC_ORBIT_TOP);
         5'd26: r = mk(OP_FINISH, SEL_A,   SEL_A,   SEL_A,   FL_END,  '0);
         default: r = mk(OP_NOP,  SEL_A,   SEL_A,   SEL_A,   FL_END,  '0);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/cetto_mul.sv
// ----------------------------------------------------------------------------
// cetto_mul
// Fixed-point 64x64 multiplier built on one 32x32 multiplier. Forms the
// exact magnitude product over four partial products, drops the fraction
// bits with truncation toward zero and saturates the signed result.
// ----------------------------------------------------------------------------
`default_nettype none

module cetto_mul #(
   parameter int FRAC_BITS = cetto_pkg::FRAC_BITS_DEF
) (
   input  wire  logic                                     clock,
   input  wire  logic                                     reset,
   input  wire  logic                                     start,
   input  wire  logic signed [cetto_pkg::WORK_WIDTH-1:0]  x,
   input  wire  logic signed [cetto_pkg::WORK_WIDTH-1:0]  y,
   output logic                                           done,
   output logic signed [cetto_pkg::WORK_WIDTH-1:0]        product
);
   import cetto_pkg::*;

   localparam int W  = WORK_WIDTH;
   localparam int HW = HALF_WIDTH;

   localparam logic [2:0] PP_LOLO  = 3'd0;
   localparam logic [2:0] PP_LOHI  = 3'd1;
   localparam logic [2:0] PP_HILO  = 3'd2;
   localparam logic [2:0] PP_HIHI  = 3'd3;
   localparam logic [2:0] ACC_LAST = 3'd4;
   localparam logic [2:0] ROUND    = 3'd5;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [2:0]           step_ff, step_in;
   logic [W-1:0]         xm_ff, xm_in;
   logic [W-1:0]         ym_ff, ym_in;
   logic                 neg_ff, neg_in;
   logic [W-1:0]         pp_ff, pp_in;
   logic [2*W-1:0]       acc_ff, acc_in;
   logic signed [W-1:0]  product_ff, product_in;
   logic [2*W-1:0]       acc_shift;
   logic                 ovf;
   logic [W-1:0]         rlo;

   always_comb begin
      acc_shift = acc_ff >> FRAC_BITS;
      ovf       = |acc_shift[2*W-1:W-1];
      rlo       = acc_shift[W-1:0];
   end

   always_comb begin
      run_in     = run_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      xm_in      = xm_ff;
      ym_in      = ym_ff;
      neg_in     = neg_ff;
      pp_in      = pp_ff;
      acc_in     = acc_ff;
      product_in = product_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = PP_LOLO;
         xm_in   = x[W-1] ? W'(WORK_ZERO - x) : W'(x);
         ym_in   = y[W-1] ? W'(WORK_ZERO - y) : W'(y);
         neg_in  = x[W-1] ^ y[W-1];
         acc_in  = '0;
      end else if (run_ff) begin
         step_in = step_ff + 3'd1;
         // Each partial product is registered and added into the accumulator in the next cycle.
         case (step_ff)
            PP_LOLO: begin
               pp_in = W'(xm_ff[HW-1:0]) * W'(ym_ff[HW-1:0]);
            end
            PP_LOHI: begin
               pp_in  = W'(xm_ff[HW-1:0]) * W'(ym_ff[W-1:HW]);
               acc_in = acc_ff + {{W{1'b0}}, pp_ff};
            end
            PP_HILO: begin
               pp_in  = W'(xm_ff[W-1:HW]) * W'(ym_ff[HW-1:0]);
               acc_in = acc_ff + {{HW{1'b0}}, pp_ff, {HW{1'b0}}};
            end
            PP_HIHI: begin
               pp_in  = W'(xm_ff[W-1:HW]) * W'(ym_ff[W-1:HW]);
               acc_in = acc_ff + {{HW{1'b0}}, pp_ff, {HW{1'b0}}};
            end
            ACC_LAST: begin
               acc_in = acc_ff + {pp_ff, {W{1'b0}}};
            end
            ROUND: begin
               if (neg_ff) begin
                  product_in = ovf ? WORK_MIN : WORK_ZERO - $signed(rlo);
               end else begin
                  product_in = ovf ? WORK_MAX : $signed(rlo);
               end
               done_in = 1'b1;
               run_in  = 1'b0;
            end
            default: begin
               run_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      xm_ff      <= xm_in;
      ym_ff      <= ym_in;
      neg_ff     <= neg_in;
      pp_ff      <= pp_in;
      acc_ff     <= acc_in;
      product_ff <= product_in;
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule

`default_nettype wire

>>> rtl/cetto_datapath.sv
// ----------------------------------------------------------------------------
// cetto_datapath
// Working registers, saturating adder, shared multiplier, iteration counts,
// escape-code formation and the configuration registers. Executes one
// command from the controller per cycle, none while a product is pending, and reports status back.
// ----------------------------------------------------------------------------
`default_nettype none

module cetto_datapath #(
   parameter int COORD_WIDTH = cetto_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = cetto_pkg::FRAC_BITS_DEF
) (
   input  wire  logic                                          clock,
   input  wire  logic                                          reset,
   input  wire  cetto_pkg::cmd_type                            cmd,
   output cetto_pkg::status_type                               status,
   input  wire  logic signed [COORD_WIDTH-1:0]                 req_a_coord,
   input  wire  logic signed [COORD_WIDTH-1:0]                 req_b_coord,
   input  wire  logic                                          csr_wr_en,
   input  wire  logic [cetto_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  wire  logic [cetto_pkg::CSR_DATA_WIDTH-1:0]          csr_wdata,
   output logic                                                rsp_valid,
   output logic signed [cetto_pkg::CODE_WIDTH-1:0]             rsp_color_code
);
   import cetto_pkg::*;

   localparam int W = WORK_WIDTH;
   localparam int CODE_PAD = CODE_WIDTH - COUNT_WIDTH - 1;
   localparam logic signed [W-1:0] TEN = W'(10) << FRAC_BITS;

   // Configuration.
   logic                   sign_a_ff;
   logic                   sign_b_ff;
   logic [COUNT_WIDTH-1:0] max_iter_ff;

   // Working registers.
   logic signed [W-1:0] a_ff, a_in;
   logic signed [W-1:0] re_ff, re_in;
   logic signed [W-1:0] im_ff, im_in;
   logic signed [W-1:0] re2_ff, re2_in;
   logic signed [W-1:0] im2_ff, im2_in;
   logic signed [W-1:0] a3_ff, a3_in;
   logic signed [W-1:0] bre_ff, bre_in;
   logic signed [W-1:0] bim_ff, bim_in;
   logic signed [W-1:0] t1_ff, t1_in;
   logic signed [W-1:0] t2_ff, t2_in;
   logic signed [W-1:0] p0_ff, p0_in;
   logic signed [W-1:0] p1_ff, p1_in;
   logic [COUNT_WIDTH-1:0] n_ff, n_in;
   logic [COUNT_WIDTH-1:0] i_ff, i_in;
   logic                   im_pos_ff, im_pos_in;
   logic                   orbit2_ff, orbit2_in;
   sel_type                mul_dst_ff, mul_dst_in;
   logic signed [CODE_WIDTH-1:0] code_ff, code_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic signed [W-1:0] a_ext, b_ext;
   logic signed [W-1:0] opa, opb, alu_res;
   logic                mul_start, mul_done;
   logic signed [W-1:0] mul_product;
   logic                w_en;
   sel_type             w_sel;
   logic signed [W-1:0] w_data;
   logic signed [CODE_WIDTH-1:0] code_calc;
   logic                i_lim, n_lim;

   assign a_ext = {{(W-COORD_WIDTH){req_a_coord[COORD_WIDTH-1]}}, req_a_coord};
   assign b_ext = {{(W-COORD_WIDTH){req_b_coord[COORD_WIDTH-1]}}, req_b_coord};

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_a_ff   <= SIGN_A_RESET;
         sign_b_ff   <= SIGN_B_RESET;
         max_iter_ff <= MAX_ITER_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SIGN_A:   sign_a_ff   <= csr_wdata[0];
            CSR_SIGN_B:   sign_b_ff   <= csr_wdata[0];
            CSR_MAX_ITER: max_iter_ff <= csr_wdata[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cmd.src_a)
         SEL_A:   opa = a_ff;
         SEL_RE:  opa = re_ff;
         SEL_IM:  opa = im_ff;
         SEL_RE2: opa = re2_ff;
         SEL_IM2: opa = im2_ff;
         SEL_A3:  opa = a3_ff;
         SEL_BRE: opa = bre_ff;
         SEL_BIM: opa = bim_ff;
         SEL_T1:  opa = t1_ff;
         SEL_T2:  opa = t2_ff;
         SEL_P0:  opa = p0_ff;
         SEL_P1:  opa = p1_ff;
         default: opa = WORK_ZERO;
      endcase
   end

   always_comb begin
      case (cmd.src_b)
         SEL_A:   opb = a_ff;
         SEL_RE:  opb = re_ff;
         SEL_IM:  opb = im_ff;
         SEL_RE2: opb = re2_ff;
         SEL_IM2: opb = im2_ff;
         SEL_A3:  opb = a3_ff;
         SEL_BRE: opb = bre_ff;
         SEL_BIM: opb = bim_ff;
         SEL_T1:  opb = t1_ff;
         SEL_T2:  opb = t2_ff;
         SEL_P0:  opb = p0_ff;
         SEL_P1:  opb = p1_ff;
         default: opb = WORK_ZERO;
      endcase
   end

   assign alu_res = (cmd.op == OP_SUB) ? sat_sub(opa, opb) : sat_add(opa, opb);

   cetto_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (opa),
      .y       (opb),
      .done    (mul_done),
      .product (mul_product)
   );

   // The controller issues nothing while a product is pending, so the
   // multiplier and the adder never write in the same cycle.
   always_comb begin
      w_en   = mul_done || (cmd.valid && (cmd.op == OP_ADD || cmd.op == OP_SUB));
      w_sel  = mul_done ? mul_dst_ff : cmd.dst;
      w_data = mul_done ? mul_product : alu_res;
   end

   always_comb begin
      i_lim = i_ff >= max_iter_ff;
      n_lim = n_ff >= max_iter_ff;
      if (sign_a_ff == sign_b_ff) begin
         if (i_lim && n_lim) begin
            code_calc = CODE_BOUNDED;
         end else if (i_ff < n_ff) begin
            code_calc = {{CODE_PAD{1'b0}}, n_ff, 1'b0};
         end else begin
            code_calc = {{CODE_PAD{1'b0}}, i_ff, 1'b1};
         end
      end else begin
         if (i_lim) begin
            code_calc = CODE_BOUNDED;
         end else if (im_pos_ff) begin
            code_calc = {{CODE_PAD{1'b0}}, i_ff, 1'b1};
         end else begin
            code_calc = {{CODE_PAD{1'b0}}, i_ff, 1'b0} + CODE_BAND_OFFSET;
         end
      end
   end

   always_comb begin
      a_in         = a_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      re2_in       = re2_ff;
      im2_in       = im2_ff;
      a3_in        = a3_ff;
      bre_in       = bre_ff;
      bim_in       = bim_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      im_pos_in    = im_pos_ff;
      orbit2_in    = orbit2_ff;
      mul_dst_in   = mul_dst_ff;
      code_in      = code_ff;
      rsp_valid_in = 1'b0;
      mul_start    = 1'b0;

      if (w_en) begin
         case (w_sel)
            SEL_RE2: re2_in = w_data;
            SEL_IM2: im2_in = w_data;
            SEL_A3:  a3_in  = w_data;
            SEL_T1:  t1_in  = w_data;
            SEL_T2:  t2_in  = w_data;
            SEL_P0:  p0_in  = w_data;
            SEL_P1:  p1_in  = w_data;
            default: ;
         endcase
      end

      if (cmd.valid) begin
         case (cmd.op)
            OP_LOAD: begin
               a_in   = a_ext;
               bre_in = sign_b_ff ? b_ext : WORK_ZERO;
               bim_in = sign_b_ff ? WORK_ZERO : b_ext;
            end
            OP_MUL: begin
               mul_start  = 1'b1;
               mul_dst_in = cmd.dst;
            end
            OP_NEGA: begin
               // a*a is never negative, so this negation cannot overflow.
               if (!sign_a_ff) begin
                  a3_in = WORK_ZERO - a3_ff;
               end
            end
            OP_INITP: begin
               re_in     = sign_a_ff ? a_ff : WORK_ZERO;
               im_in     = sign_a_ff ? WORK_ZERO : a_ff;
               n_in      = '0;
               orbit2_in = 1'b0;
            end
            OP_INITN: begin
               re_in     = sign_a_ff ? WORK_ZERO - a_ff : WORK_ZERO;
               im_in     = sign_a_ff ? WORK_ZERO : WORK_ZERO - a_ff;
               n_in      = '0;
               orbit2_in = 1'b1;
            end
            OP_STEP: begin
               re_in = p0_ff;
               im_in = p1_ff;
               n_in  = n_ff + COUNT_WIDTH'(1);
            end
            OP_SAVE: begin
               if (!orbit2_ff) begin
                  i_in      = n_ff;
                  im_pos_in = im_ff > WORK_ZERO;
               end
            end
            OP_FINISH: begin
               code_in      = code_calc;
               rsp_valid_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      re_ff      <= re_in;
      im_ff      <= im_in;
      re2_ff     <= re2_in;
      im2_ff     <= im2_in;
      a3_ff      <= a3_in;
      bre_ff     <= bre_in;
      bim_ff     <= bim_in;
      t1_ff      <= t1_in;
      t2_ff      <= t2_in;
      p0_ff      <= p0_in;
      p1_ff      <= p1_in;
      n_ff       <= n_in;
      i_ff       <= i_in;
      im_pos_ff  <= im_pos_in;
      orbit2_ff  <= orbit2_in;
      mul_dst_ff <= mul_dst_in;
      code_ff    <= code_in;
   end

   always_comb begin
      status.mul_done  = mul_done;
      status.at_limit  = n_ff >= max_iter_ff;
      status.escaped   = !(p0_ff < TEN);
      status.pair_mode = sign_a_ff == sign_b_ff;
      status.orbit2    = orbit2_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_color_code = code_ff;

endmodule

`default_nettype wire

>>> rtl/cetto_ctrl.sv
// ----------------------------------------------------------------------------
// cetto_ctrl
// Sequencer for the escape-time unit. Steps through the program in the
// package, issues one datapath command per cycle, waits on the multiplier
// and branches on the limit, escape and orbit status.
// ----------------------------------------------------------------------------
`default_nettype none

module cetto_ctrl (
   input  wire  logic                    clock,
   input  wire  logic                    reset,
   input  wire  logic                    start,
   output logic                          busy,
   output cetto_pkg::cmd_type            cmd,
   input  wire  cetto_pkg::status_type   status
);
   import cetto_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0] state_ff, state_in;
   pc_type     pc_ff, pc_in;
   instr_type  instr;
   pc_type     pc_next;
   logic       taken;

   assign instr   = prog_rom(pc_ff);
   assign pc_next = pc_ff + 5'd1;

   always_comb begin
      case (instr.flow)
         FL_JUMP:      taken = 1'b1;
         FL_IF_LIMIT:  taken = status.at_limit;
         FL_IF_ESCAPE: taken = status.escaped;
         FL_ORBIT_END: taken = !(status.pair_mode && !status.orbit2);
         default:      taken = 1'b0;
      endcase
   end

   always_comb begin
      cmd.valid = 1'b0;
      cmd.op    = instr.op;
      cmd.src_a = instr.src_a;
      cmd.src_b = instr.src_b;
      cmd.dst   = instr.dst;
      state_in  = state_ff;
      pc_in     = pc_ff;
      case (state_ff)
         ST_IDLE: begin
            // The program counter rests on the load step while idle.
            if (start) begin
               cmd.valid = 1'b1;
               pc_in     = pc_next;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.valid = 1'b1;
            if (instr.op == OP_MUL) begin
               state_in = ST_WAIT;
            end else if (instr.flow == FL_END) begin
               pc_in    = '0;
               state_in = ST_IDLE;
            end else begin
               pc_in = taken ? instr.target : pc_next;
            end
         end
         ST_WAIT: begin
            if (status.mul_done) begin
               pc_in    = pc_next;
               state_in = ST_RUN;
            end
         end
         default: begin
            pc_in    = '0;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

endmodule

`default_nettype wire

>>> rtl/cubic_escape_time_two_orbits_unit.sv
// ----------------------------------------------------------------------------
// cubic_escape_time_two_orbits_unit
// When the signs agree a second orbit runs. Each step forms seven 64x64 products on
// one 32x32 multiplier. One point at a time; busy drops with rsp_valid, so a start
// can be taken then. Synchronous reset returns the sequencer to idle and the
// configuration registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_escape_time_two_orbits_unit #(
   parameter int COORD_WIDTH = cetto_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = cetto_pkg::FRAC_BITS_DEF
) (
   input  wire  logic                                     clock,
   input  wire  logic                                     reset,
   input  wire  logic                                     start,
   output logic                                           busy,
   input  wire  logic signed [COORD_WIDTH-1:0]            req_a_coord,
   input  wire  logic signed [COORD_WIDTH-1:0]            req_b_coord,
   output logic                                           rsp_valid,
   output logic signed [cetto_pkg::CODE_WIDTH-1:0]        rsp_color_code,
   input  wire  logic                                     csr_wr_en,
   input  wire  logic [cetto_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire  logic [cetto_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import cetto_pkg::*;

   cmd_type    cmd;
   status_type status;

   cetto_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   cetto_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_a_coord    (req_a_coord),
      .req_b_coord    (req_b_coord),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_color_code (rsp_color_code)
   );

`ifndef SYNTHESIS
   // A result beat is only produced as the sequencer returns to idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while the sequencer is busy");

   a_start_takes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted point did not start the sequencer");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result beats in consecutive cycles");

   // After a multiply is issued the sequencer holds off until the product lands.
   a_mul_wait: assert property (@(posedge clock) disable iff (reset)
      (cmd.valid && cmd.op == OP_MUL) |=> !cmd.valid)
      else $error("command issued while a product is pending");
`endif

endmodule

`default_nettype wire
